// ===== rtl/video_port_vram_window_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for video_port_vram_window_core
// Clocked on clk and disabled during rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PORT_VRAM_WINDOW_CORE_MACROS_SVH
`define VIDEO_PORT_VRAM_WINDOW_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPVW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPVW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vpvw_pkg.sv =====
// ----------------------------------------------------------------------------
// vpvw_pkg
// Shared types, port codes and the power-up screen text of the video port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpvw_pkg;

  localparam int ADDR_W = 14;

  localparam logic [ADDR_W-1:0] ADDR_RESET = 14'h1800;

  // I/O port codes
  localparam logic [7:0] PORT_DATA = 8'h98;
  localparam logic [7:0] PORT_ADDR = 8'h99;
  localparam logic [7:0] PORT_LAST = 8'h9B;

  // Address load sequence on the address port
  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // Source of the returned byte
  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_WIN  = 2'd1,
    SEL_PORT = 2'd2
  } sel_t;

  // Access request to the screen window RAM
  typedef struct packed {
    logic rd;
    logic wr;
  } ram_ctl_t;

  // Power-up contents of the screen window: "MSX BASIC", then zeros
  function automatic logic [7:0] boot_char(input logic [31:0] idx);
    logic [7:0] c;
    case (idx)
      32'd0:   c = 8'h4D;
      32'd1:   c = 8'h53;
      32'd2:   c = 8'h58;
      32'd3:   c = 8'h20;
      32'd4:   c = 8'h42;
      32'd5:   c = 8'h41;
      32'd6:   c = 8'h53;
      32'd7:   c = 8'h49;
      32'd8:   c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/vpvw_window_ram.sv =====
// ----------------------------------------------------------------------------
// vpvw_window_ram
// Screen window RAM with registered read and a fill pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpvw_window_ram
  import vpvw_pkg::*;
#(
  parameter int WINDOW_BYTES = 768,
  localparam int OFF_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  ram_ctl_t         ctl,
  input  logic [OFF_W-1:0] offset,
  input  logic [7:0]       wr_data,
  output logic [7:0]       rd_data,
  output logic             busy
);

  localparam logic [OFF_W-1:0] LAST_IDX = OFF_W'(WINDOW_BYTES - 1);

  logic [7:0]       mem [WINDOW_BYTES];
  logic [OFF_W-1:0] clr_idx;

  // fill pass: one entry per cycle, boot text first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == LAST_IDX) begin
        busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= boot_char(32'(clr_idx));
    end else if (ctl.wr) begin
      mem[offset] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= mem[offset];
    end
  end

endmodule

// ===== rtl/video_port_vram_window_core.sv =====
// ----------------------------------------------------------------------------
// video_port_vram_window_core
// I/O port front end of a video processor with a screen window of video RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, kind/port/data) carries one processor
//   I/O access per item. Output channel (out_valid/out_stall, read_data)
//   returns exactly one byte per item, in order.
//   Port 0x98 moves a byte to or from the screen window at the current video
//   address and steps the address; port 0x99 loads the address in two
//   accesses; 0x9A/0x9B do nothing; all other ports hit a 256-byte store.
//   Config channel (cfg_valid/cfg_ready, cfg_data) sets the window base;
//   cfg_ready is always high. Write it only while the block is idle.
// Throughput and pipeline:
//   One item per cycle sustained unless out_stall or the RAM fill holds the
//   input. An accepted item passes stage 1, with the synchronous RAM read beside it, then the
//   output register. The RAM read port sets the pipeline depth.
// Reset:
//   rst is synchronous. After reset the window RAM is refilled one entry per
//   cycle with the boot text; in_stall is high meanwhile.
// Stalls:
//   When out_stall holds a result, the pipeline freezes and in_stall rises
//   in the same cycle; no item is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "video_port_vram_window_core_macros.svh"

module video_port_vram_window_core
  import vpvw_pkg::*;
#(
  parameter int WINDOW_BYTES = 768
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data,
  // input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [7:0]        port,
  input  logic [7:0]        data,
  // result item channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data
);

  localparam int OFF_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam logic [ADDR_W:0] WIN_LIMIT = (ADDR_W + 1)'(WINDOW_BYTES);

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] window_base;
  logic [ADDR_W-1:0] video_address;
  logic [ADDR_W-1:0] video_address_next;
  logic              write_mode;
  logic              write_mode_next;
  phase_t            phase;
  phase_t            phase_next;

  // port store: data array plus one valid bit per entry (reads zero until written)
  logic [7:0]        pstore [256];
  logic [255:0]      pvalid;
  logic [7:0]        pdata_q;
  logic              pvalid_q;

  // stage 1: item waiting on the RAM read
  logic              s1_valid;
  sel_t              s1_sel;
  logic [7:0]        s1_data;

  // window RAM interface
  ram_ctl_t          ram_ctl;
  logic [OFF_W-1:0]  ram_offset;
  logic [7:0]        ram_rd_data;
  logic              ram_busy;

  // decode
  logic              adv;
  logic              acc;
  logic              is_data;
  logic              is_addr;
  logic              is_unused;
  logic [ADDR_W-1:0] win_diff;
  logic              in_win;
  sel_t              sel_next;

  // --------------------------------------------------------------------------
  // Handshake: advance the pipeline whenever the output register is free
  // --------------------------------------------------------------------------
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = ram_busy || !adv;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Decode the access against the current state
  // --------------------------------------------------------------------------
  assign win_diff   = video_address - window_base;
  assign in_win     = {1'b0, win_diff} < WIN_LIMIT;
  assign ram_offset = win_diff[OFF_W-1:0];

  always_comb begin
    is_data   = (port == PORT_DATA);
    is_addr   = (port == PORT_ADDR);
    is_unused = port inside {[PORT_ADDR + 8'd1 : PORT_LAST]};
  end

  always_comb begin
    video_address_next = video_address;
    write_mode_next    = write_mode;
    phase_next         = phase;
    sel_next           = SEL_DATA;
    ram_ctl            = '0;
    if (acc) begin
      if (is_data) begin
        // data port: direction follows the access, then step the address
        write_mode_next    = kind;
        ram_ctl.wr         = in_win && kind;
        ram_ctl.rd         = in_win && !kind;
        sel_next           = (in_win && !kind) ? SEL_WIN : SEL_DATA;
        video_address_next = video_address + 1'b1;
        phase_next         = PH_LOW;
      end else if (is_addr) begin
        case (phase)
          PH_LOW: begin
            video_address_next = {video_address[ADDR_W-1:8], data};
            phase_next         = PH_HIGH;
          end
          PH_HIGH: begin
            video_address_next = {data[5:0], video_address[7:0]};
            write_mode_next    = data[6];
            phase_next         = PH_DONE;
          end
          default: begin
            // locked until the data port is used
            phase_next = phase;
          end
        endcase
      end else if (!is_unused) begin
        sel_next = kind ? SEL_DATA : SEL_PORT;
      end
    end
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= ADDR_RESET;
      video_address <= ADDR_RESET;
      write_mode    <= 1'b1;
      phase         <= PH_LOW;
    end else begin
      if (cfg_valid) begin
        window_base <= cfg_data;
      end
      video_address <= video_address_next;
      write_mode    <= write_mode_next;
      phase         <= phase_next;
    end
  end

  // --------------------------------------------------------------------------
  // Port store: write on accepted writes, registered read on accepted reads
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (acc && !is_data && !is_addr && !is_unused && kind) begin
      pstore[port] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pdata_q <= pstore[port];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid   <= '0;
      pvalid_q <= 1'b0;
    end else if (acc) begin
      pvalid_q <= pvalid[port];
      if (!is_data && !is_addr && !is_unused && kind) begin
        pvalid[port] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Screen window RAM
  // --------------------------------------------------------------------------
  vpvw_window_ram #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_window_ram (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ram_ctl),
    .offset (ram_offset),
    .wr_data(data),
    .rd_data(ram_rd_data),
    .busy   (ram_busy)
  );

  // --------------------------------------------------------------------------
  // Stage 1 and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sel  <= sel_next;
      s1_data <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      case (s1_sel)
        SEL_WIN:  read_data <= ram_rd_data;
        SEL_PORT: read_data <= pvalid_q ? pdata_q : 8'h00;
        default:  read_data <= s1_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `VPVW_ASSERT_NEXT(a_accept_fills_stage, acc, s1_valid, "accepted item missing from stage 1")
  `VPVW_ASSERT_IMPL(a_no_accept_in_fill, ram_busy, in_stall, "item accepted during RAM fill")
  `VPVW_ASSERT_NEXT(a_data_port_step, acc && is_data,
    (video_address == $past(video_address) + 1'b1) && (phase == PH_LOW),
    "data port did not step address or clear phase")
  `VPVW_ASSERT_NEXT(a_addr_port_locked, acc && is_addr && (phase == PH_DONE),
    $stable(video_address) && (phase == PH_DONE), "address port not ignored after two loads")
  `VPVW_ASSERT_NEXT(a_write_mode_follows, acc && is_data, write_mode == $past(kind),
    "write mode does not follow data port direction")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: video port front end with screen window RAM
// Drives processor I/O accesses through the item channel and predicts each
// returned byte with a behavioral copy of the port logic. Results are checked
// in order against that prediction. The window base moves through its
// extremes between phases, and both sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import vpvw_pkg::*;

  localparam int WIN_BYTES   = 768;
  localparam int STALL_LIMIT = 4000;  // covers the window fill after reset
  localparam int PIPE_SLACK  = 8;     // settling margin after the last result comes back

  // access direction on the kind field
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // video port between the address port and the last video port; no effect
  localparam logic [7:0] PORT_SPARE = 8'h9A;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              kind      = KIND_READ;
  logic [7:0]        port      = 8'h00;
  logic [7:0]        data      = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        read_data;

  video_port_vram_window_core #(
    .WINDOW_BYTES(WIN_BYTES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .port      (port),
    .data      (data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the port logic
  // --------------------------------------------------------------------------
  logic [7:0]        screen_mem [WIN_BYTES];
  logic [7:0]        port_mem [256];
  logic [ADDR_W-1:0] vid_addr;
  logic [ADDR_W-1:0] win_base;
  phase_t            load_phase;

  logic [7:0] expected_read_data [$];

  int src_gap_pct    = 0;   // chance per cycle that the sender idles
  int sink_stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_len       = 0;   // cycles left in a forced receiver hold
  int err_count      = 0;
  int quiet_cycles   = 0;
  logic [7:0] want_byte;

  // Bring the copy to its power-up state: boot text at the window start.
  function automatic void reset_vdp_model();
    string boot_text;
    boot_text = "MSX BASIC";
    for (int i = 0; i < WIN_BYTES; i++) begin
      screen_mem[i] = (i < boot_text.len()) ? boot_text[i] : 8'h00;
    end
    for (int i = 0; i < 256; i++) begin
      port_mem[i] = 8'h00;
    end
    vid_addr   = ADDR_RESET;
    win_base   = ADDR_RESET;
    load_phase = PH_LOW;
  endfunction

  // Apply one access to the copy and return the byte the processor gets back.
  function automatic logic [7:0] predict_access(input logic k, input logic [7:0] p,
                                                input logic [7:0] d);
    logic [7:0]        rd;
    logic [ADDR_W-1:0] off;
    rd = d;
    if (p == PORT_DATA) begin
      // offset wraps at 14 bits, so the window may run past the top address
      off = vid_addr - win_base;
      if (off < WIN_BYTES) begin
        if (k == KIND_WRITE) begin
          screen_mem[off] = d;
        end else begin
          rd = screen_mem[off];
        end
      end
      vid_addr   = vid_addr + 1'b1;
      load_phase = PH_LOW;
    end else if (p == PORT_ADDR) begin
      case (load_phase)
        PH_LOW: begin
          vid_addr[7:0] = d;
          load_phase    = PH_HIGH;
        end
        PH_HIGH: begin
          vid_addr[ADDR_W-1:8] = d[5:0];
          load_phase           = PH_DONE;
        end
        default: begin
          // both halves loaded: ignore until the data port is used
        end
      endcase
    end else if (p > PORT_ADDR && p <= PORT_LAST) begin
      // spare video ports: echo only
    end else if (k == KIND_WRITE) begin
      port_mem[p] = d;
    end else begin
      rd = port_mem[p];
    end
    return rd;
  endfunction

  // --------------------------------------------------------------------------
  // Sender, receiver and checker
  // --------------------------------------------------------------------------

  // Offer one item, idling first at the current gap rate; predict on accept.
  task automatic send_access(input logic k, input logic [7:0] p, input logic [7:0] d);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    port     <= p;
    data     <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_read_data.push_back(predict_access(k, p, d));
  endtask

  // Receiver stall: a forced hold takes priority over random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len  <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_read_data.size() == 0) begin
        report_mismatch($sformatf("read_data %02h with no access pending", read_data));
      end else begin
        want_byte = expected_read_data.pop_front();
        if (read_data !== want_byte) begin
          report_mismatch($sformatf("read_data %02h, predicted %02h", read_data, want_byte));
        end
      end
    end
  end

  // Abort when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic set_traffic(input int gap_pct, input int stall_pct);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  function automatic logic rand_kind();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Drop valid and wait until every predicted byte has come back.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_read_data.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Load the video address in two address port accesses. Clear a pending
  // load sequence first through the data port, or the load would be misplaced or ignored.
  task automatic load_address(input logic [ADDR_W-1:0] a);
    logic [1:0] top;
    top = 2'($urandom_range(3));
    if (load_phase != PH_LOW) begin
      send_access(rand_kind(), PORT_DATA, rand_byte());
    end
    send_access(rand_kind(), PORT_ADDR, a[7:0]);
    send_access(rand_kind(), PORT_ADDR, {top, a[ADDR_W-1:8]});
  endtask

  // Write the window base while idle and track it in the copy.
  task automatic set_window_base(input logic [ADDR_W-1:0] base);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_base = base;
  endtask

  // Store ports cluster on a few numbers so reads often hit earlier writes.
  function automatic logic [7:0] pick_store_port();
    logic [7:0] p;
    if ($urandom_range(1) == 0) begin
      p = 8'($urandom_range(7));
    end else begin
      do p = rand_byte(); while (p >= PORT_DATA && p <= PORT_LAST);
    end
    return p;
  endfunction

  // Address loads followed by data port bursts around the window, the most likely pick,
  // mixed with store accesses, broken load sequences and raw noise.
  task automatic run_mixed_traffic(input int n_items);
    int                sent;
    int                pick;
    int                burst;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] target;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        span   = ADDR_W'($urandom_range(WIN_BYTES + 63));
        target = win_base + span - 14'd32;
        load_address(target);
        burst = $urandom_range(1, 12);
        repeat (burst) send_access(rand_kind(), PORT_DATA, rand_byte());
        sent += 2 + burst;
      end else if (pick < 60) begin
        send_access(rand_kind(), pick_store_port(), rand_byte());
        sent++;
      end else if (pick < 72) begin
        send_access(rand_kind(), PORT_DATA, rand_byte());
        sent++;
      end else if (pick < 85) begin
        burst = $urandom_range(1, 3);
        repeat (burst) send_access(rand_kind(), PORT_ADDR, rand_byte());
        sent += burst;
      end else begin
        send_access(rand_kind(), rand_byte(), rand_byte());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Read the power-up text and the first blank byte after it.
  task automatic test_boot_text();
    repeat (10) send_access(KIND_READ, PORT_DATA, 8'hEE);
  endtask

  // Store extremes and the ports right beside the video range.
  task automatic test_port_store();
    send_access(KIND_WRITE, 8'h00, 8'hFF);
    send_access(KIND_WRITE, 8'hFF, 8'h00);
    send_access(KIND_READ,  8'h00, 8'h00);
    send_access(KIND_READ,  8'hFF, 8'hFF);
    send_access(KIND_WRITE, PORT_DATA - 8'd1, 8'h5A);
    send_access(KIND_READ,  PORT_LAST + 8'd1, 8'hA5);
  endtask

  // Spare video ports echo the bus in both directions.
  task automatic test_spare_ports();
    send_access(KIND_WRITE, PORT_SPARE, 8'h12);
    send_access(KIND_READ,  PORT_SPARE, 8'h34);
    send_access(KIND_WRITE, PORT_LAST,  8'h56);
    send_access(KIND_READ,  PORT_LAST,  8'h78);
  endtask

  // Two-step address load, ignored third load, top address wrap, the last
  // window byte, the first byte past it, and a half load cut short.
  task automatic test_address_load();
    send_access(KIND_WRITE, PORT_ADDR, 8'hFF);
    send_access(KIND_READ,  PORT_ADDR, 8'hFF);
    send_access(KIND_WRITE, PORT_ADDR, 8'h00);
    send_access(KIND_WRITE, PORT_DATA, 8'hA5);
    send_access(KIND_READ,  PORT_DATA, 8'h3C);
    load_address(ADDR_W'(ADDR_RESET + WIN_BYTES - 1));
    send_access(KIND_WRITE, PORT_DATA, 8'h81);
    load_address(ADDR_W'(ADDR_RESET + WIN_BYTES - 1));
    send_access(KIND_READ,  PORT_DATA, 8'h00);
    send_access(KIND_READ,  PORT_DATA, 8'h99);
    send_access(KIND_WRITE, PORT_ADDR, 8'h00);
    send_access(KIND_READ,  PORT_DATA, 8'h00);
  endtask

  // Window at address zero: last byte inside and the first one outside.
  task automatic test_base_floor();
    set_window_base('0);
    load_address(ADDR_W'(WIN_BYTES - 1));
    send_access(KIND_WRITE, PORT_DATA, 8'h33);
    send_access(KIND_WRITE, PORT_DATA, 8'h44);
    load_address(ADDR_W'(WIN_BYTES - 1));
    send_access(KIND_READ,  PORT_DATA, 8'h00);
    send_access(KIND_READ,  PORT_DATA, 8'h55);
    run_mixed_traffic(150);
  endtask

  // Window at the top address: it wraps on to address zero.
  task automatic test_base_ceiling();
    set_window_base('1);
    load_address('1);
    send_access(KIND_WRITE, PORT_DATA, 8'h11);
    send_access(KIND_WRITE, PORT_DATA, 8'h22);
    load_address('1);
    send_access(KIND_READ,  PORT_DATA, 8'h00);
    send_access(KIND_READ,  PORT_DATA, 8'h00);
    run_mixed_traffic(150);
  endtask

  task automatic test_base_random();
    set_window_base(ADDR_W'($urandom_range(16383)));
    run_mixed_traffic(150);
  endtask

  // Hold the receiver for a long stretch while the sender keeps offering
  // items back to back, so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    set_traffic(0, 0);
    hold_len <= 80;
    run_mixed_traffic(40);
  endtask

  initial begin
    reset_vdp_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_traffic(0, 0);
    test_boot_text();
    test_port_store();
    test_spare_ports();
    test_address_load();

    // reset base, every traffic pattern
    run_mixed_traffic(200);
    set_traffic(69, 0);
    run_mixed_traffic(150);
    set_traffic(0, 69);
    run_mixed_traffic(150);
    set_traffic(7, 7);
    run_mixed_traffic(150);

    test_base_floor();
    set_traffic(0, 0);
    test_base_ceiling();
    set_traffic(69, 0);
    test_base_random();
    test_backpressure();

    set_window_base(ADDR_RESET);
    set_traffic(0, 69);
    run_mixed_traffic(150);

    wait_quiet();
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vpvw_pkg.sv
rtl/vpvw_window_ram.sv
rtl/video_port_vram_window_core.sv
dv/tb_top.sv
